@@ src/rsf_pkg.sv @@
// Shared types, constants and helpers of the RGB 3x3 smoothing filter.
package rsf_pkg;

	// Frame geometry and register widths.
	localparam int MaxWidth   = 1024;
	localparam int MaxHeight  = 4096;
	localparam int AddrW      = 10;
	localparam int ColW       = 10;
	localparam int RowW       = 12;
	localparam int WidthRegW  = 11;
	localparam int HeightRegW = 13;
	localparam int ModeW      = 2;
	localparam int CfgIdxW    = 2;
	localparam int CfgDataW   = 13;

	// Reset values of the configuration registers.
	localparam logic [WidthRegW-1:0]  WidthReset  = 11'd640;
	localparam logic [HeightRegW-1:0] HeightReset = 13'd480;

	// Register indexes; the last code names no register and is ignored.
	localparam logic [CfgIdxW-1:0] CFG_FRAME_WIDTH  = 2'd0;
	localparam logic [CfgIdxW-1:0] CFG_FRAME_HEIGHT = 2'd1;
	localparam logic [CfgIdxW-1:0] CFG_FILTER_MODE  = 2'd2;
	localparam logic [CfgIdxW-1:0] CFG_UNUSED       = 2'd3;

	// Filter modes; the unused code behaves as box mode.
	localparam logic [ModeW-1:0] MODE_BOX    = 2'd0;
	localparam logic [ModeW-1:0] MODE_GAUSS  = 2'd1;
	localparam logic [ModeW-1:0] MODE_MEDIAN = 2'd2;

	// Input pixel: blue in the low byte.
	typedef struct packed {
		logic [7:0] in_red;
		logic [7:0] in_green;
		logic [7:0] in_blue;
	} pixel_t;

	// Filtered result with its position.
	typedef struct packed {
		logic            last_of_run;
		logic [RowW-1:0] out_row;
		logic [ColW-1:0] out_col;
		logic [7:0]      out_red;
		logic [7:0]      out_green;
		logic [7:0]      out_blue;
	} result_t;

	// One line store entry: the pixel two rows up and the one a row up.
	typedef struct packed {
		logic [23:0] above;
		logic [23:0] current;
	} line_entry_t;

	// One filter job: a 3x3 neighborhood, its valid mask and its position.
	typedef struct packed {
		logic [8:0][23:0] px;
		logic [8:0]       vld;
		logic [ColW-1:0]  col;
		logic [RowW-1:0]  row;
		logic             last;
	} job_t;

	typedef enum logic [1:0] {
		F_IDLE,
		F_READ,
		F_EMIT
	} front_state_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_SUM,
		B_RUN,
		B_DONE
	} back_state_t;

	// Gaussian weight of a neighborhood position, numbered in raster order.
	function automatic logic [2:0] gauss_weight(input logic [3:0] idx);
		logic [2:0] w;
		unique case (idx)
			4'd4: w = 3'd4;
			4'd1, 4'd3, 4'd5, 4'd7: w = 3'd2;
			default: w = 3'd1;
		endcase
		return w;
	endfunction

endpackage

@@ src/rsf_queue.sv @@
// Two-entry job queue between the window front end and the filter back end.
module rsf_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push_valid,
	output logic          push_ready,
	input  rsf_pkg::job_t push_data,
	output logic          pop_valid,
	input  logic          pop_ready,
	output rsf_pkg::job_t pop_data
);

	rsf_pkg::job_t slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       do_push;
	logic       do_pop;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid  = (count_q != 2'd0);
	assign pop_data   = slot_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) wr_ptr_q <= ~wr_ptr_q;
			if (do_pop) rd_ptr_q <= ~rd_ptr_q;
			if (do_push && !do_pop) count_q <= count_q + 2'd1;
			else if (!do_push && do_pop) count_q <= count_q - 2'd1;
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_push) slot_q[wr_ptr_q] <= push_data;
	end

endmodule

@@ src/rsf_front.sv @@
// Front end: configuration, position counters, line store, window and job issue.
module rsf_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [rsf_pkg::CfgIdxW-1:0]   cfg_index,
	input  logic [rsf_pkg::CfgDataW-1:0]  cfg_data,
	input  logic                          pixel_valid,
	output logic                          pixel_ready,
	input  rsf_pkg::pixel_t               pixel,
	output logic                          job_valid,
	input  logic                          job_ready,
	output rsf_pkg::job_t                 job,
	output logic [rsf_pkg::ModeW-1:0]     mode
);

	logic [rsf_pkg::WidthRegW-1:0]  width_q;
	logic [rsf_pkg::HeightRegW-1:0] height_q;
	logic [rsf_pkg::ModeW-1:0]      mode_q;
	logic [rsf_pkg::ColW-1:0]       col_q;
	logic [rsf_pkg::RowW-1:0]       row_q;

	rsf_pkg::front_state_t state_q, state_d;

	rsf_pkg::pixel_t           pix_q;
	logic [rsf_pkg::ColW-1:0]  c_q;
	logic [rsf_pkg::RowW-1:0]  r_q;
	logic [3:0]                pend_q;
	logic                      top_q;
	logic                      left_q;
	logic [8:0][23:0]          window_q;

	rsf_pkg::line_entry_t      line_mem [rsf_pkg::MaxWidth];
	rsf_pkg::line_entry_t      rd_q;

	logic [rsf_pkg::WidthRegW-1:0]  eff_w;
	logic [rsf_pkg::HeightRegW-1:0] eff_h;
	logic [rsf_pkg::WidthRegW-1:0]  w_last;
	logic [rsf_pkg::HeightRegW-1:0] h_last;
	logic [rsf_pkg::ColW-1:0]       cur_c;
	logic [rsf_pkg::RowW-1:0]       cur_r;
	logic                           accept;
	logic                           e_any;
	logic                           at_col_end;
	logic                           at_row_end;
	logic [rsf_pkg::WidthRegW-1:0]  c_next;
	logic [rsf_pkg::HeightRegW-1:0] r_next;
	logic [1:0]                     kind;
	logic [3:0]                     kind_hot;
	logic [3:0]                     pend_left;

	// Effective frame size and the clamped position of the incoming pixel.
	always_comb begin
		if (width_q < 11'd2) eff_w = 11'd2;
		else if (width_q > 11'(rsf_pkg::MaxWidth)) eff_w = 11'(rsf_pkg::MaxWidth);
		else eff_w = width_q;
		if (height_q < 13'd2) eff_h = 13'd2;
		else if (height_q > 13'(rsf_pkg::MaxHeight)) eff_h = 13'(rsf_pkg::MaxHeight);
		else eff_h = height_q;
		w_last = eff_w - 11'd1;
		h_last = eff_h - 13'd1;
		cur_c = ({1'b0, col_q} >= eff_w) ? w_last[rsf_pkg::ColW-1:0] : col_q;
		cur_r = ({1'b0, row_q} >= eff_h) ? h_last[rsf_pkg::RowW-1:0] : row_q;
	end

	assign mode        = mode_q;
	assign pixel_ready = (state_q == rsf_pkg::F_IDLE);
	assign accept      = pixel_valid && pixel_ready;

	// Which results the pixel in flight releases.
	assign e_any      = (r_q != '0) && (c_q != '0);
	assign at_col_end = ({1'b0, c_q} == w_last);
	assign at_row_end = ({1'b0, r_q} == h_last);
	assign c_next     = {1'b0, c_q} + 11'd1;
	assign r_next     = {1'b0, r_q} + 13'd1;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= rsf_pkg::F_IDLE;
		else state_q <= state_d;
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			rsf_pkg::F_IDLE: if (accept) state_d = rsf_pkg::F_READ;
			rsf_pkg::F_READ: state_d = e_any ? rsf_pkg::F_EMIT : rsf_pkg::F_IDLE;
			rsf_pkg::F_EMIT: if (job_ready && pend_left == 4'd0) state_d = rsf_pkg::F_IDLE;
			default: state_d = rsf_pkg::F_IDLE;
		endcase
	end

	// Configuration, counters and the window.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= rsf_pkg::WidthReset;
			height_q <= rsf_pkg::HeightReset;
			mode_q   <= rsf_pkg::MODE_BOX;
			col_q    <= '0;
			row_q    <= '0;
			pend_q   <= '0;
			window_q <= '0;
		end else begin
			if (state_q == rsf_pkg::F_READ) begin
				for (int i = 0; i < 3; i++) begin
					window_q[i*3]   <= window_q[i*3+1];
					window_q[i*3+1] <= window_q[i*3+2];
				end
				window_q[2] <= rd_q.above;
				window_q[5] <= rd_q.current;
				window_q[8] <= pix_q;
				pend_q <= {e_any && at_col_end && at_row_end, e_any && at_row_end,
					e_any && at_col_end, e_any};
				if (c_next >= eff_w) begin
					col_q <= '0;
					row_q <= (r_next >= eff_h) ? '0 : r_next[rsf_pkg::RowW-1:0];
				end else begin
					col_q <= c_next[rsf_pkg::ColW-1:0];
				end
			end else if (state_q == rsf_pkg::F_EMIT && job_ready) begin
				pend_q <= pend_left;
			end
			if (cfg_we) begin
				unique case (cfg_index)
					rsf_pkg::CFG_FRAME_WIDTH: width_q <= cfg_data[rsf_pkg::WidthRegW-1:0];
					rsf_pkg::CFG_FRAME_HEIGHT: height_q <= cfg_data;
					rsf_pkg::CFG_FILTER_MODE: mode_q <= cfg_data[rsf_pkg::ModeW-1:0];
					default: ;
				endcase
				if (cfg_index != rsf_pkg::CFG_UNUSED) begin
					col_q <= '0;
					row_q <= '0;
				end
			end
		end
	end

	// Pixel and position of the transaction in flight.
	always_ff @(posedge clk) begin
		if (accept) begin
			pix_q <= pixel;
			c_q   <= cur_c;
			r_q   <= cur_r;
		end
		if (state_q == rsf_pkg::F_READ) begin
			top_q  <= (r_q >= 12'd2);
			left_q <= (c_q >= 10'd2);
		end
	end

	// Line store: read on acceptance, written back in the next cycle.
	always_ff @(posedge clk) begin
		if (accept) rd_q <= line_mem[cur_c];
		if (state_q == rsf_pkg::F_READ) line_mem[c_q] <= '{above: rd_q.current, current: pix_q};
	end

	// Pick the next pending result in raster order.
	always_comb begin
		priority if (pend_q[0]) kind = 2'd0;
		else if (pend_q[1]) kind = 2'd1;
		else if (pend_q[2]) kind = 2'd2;
		else kind = 2'd3;
		kind_hot  = 4'b0001 << kind;
		pend_left = pend_q & ~kind_hot;
	end

	// Build the neighborhood of the selected result.
	always_comb begin
		int  rr;
		int  cx;
		logic row_ok;
		logic col_ok;
		job.px   = '0;
		job.vld  = '0;
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				rr = int'(kind[1]) + i;
				cx = int'(kind[0]) + j;
				row_ok = (i == 0) ? (kind[1] || top_q) : ((i == 2) ? !kind[1] : 1'b1);
				col_ok = (j == 0) ? (kind[0] || left_q) : ((j == 2) ? !kind[0] : 1'b1);
				if (rr < 3 && cx < 3) begin
					job.px[i*3+j]  = window_q[rr*3+cx];
					job.vld[i*3+j] = row_ok && col_ok;
				end
			end
		end
		job.col  = kind[0] ? c_q : c_q - 10'd1;
		job.row  = kind[1] ? r_q : r_q - 12'd1;
		job.last = (pend_left == 4'd0);
	end

	assign job_valid = (state_q == rsf_pkg::F_EMIT);

endmodule

@@ src/rsf_back.sv @@
// Back end: per-channel mean by restoring division, or median by rank search.
module rsf_back (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [rsf_pkg::ModeW-1:0] mode,
	input  logic                      job_valid,
	output logic                      job_ready,
	input  rsf_pkg::job_t             job,
	output logic                      result_valid,
	input  logic                      result_ready,
	output rsf_pkg::result_t          result
);

	rsf_pkg::back_state_t state_q, state_d;

	rsf_pkg::job_t    job_q;
	logic [3:0]       step_q;
	logic [3:0]       m1_q;
	logic [3:0]       m2_q;
	logic [5:0]       den_q;
	logic [5:0]       rem_q  [3];
	logic [7:0]       low_q  [3];
	logic [7:0]       quo_q  [3];
	logic [7:0]       meda_q [3];
	logic [7:0]       medb_q [3];
	rsf_pkg::result_t res_q;
	logic             res_valid_q;

	logic [12:0] sum_c [3];
	logic [4:0]  wsum_c;
	logic [13:0] num_c [3];
	logic [3:0]  cnt_c;
	logic [6:0]  trial_c [3];
	logic        fits_c  [3];
	logic [7:0]  cand_c  [3];
	logic [3:0]  rank_c  [3];
	logic [7:0]  val_c   [3];
	logic [8:0]  med_c   [3];
	logic        store_ok;

	assign job_ready    = (state_q == rsf_pkg::B_IDLE);
	assign result_valid = res_valid_q;
	assign result       = res_q;
	assign store_ok     = !res_valid_q || result_ready;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= rsf_pkg::B_IDLE;
		else state_q <= state_d;
	end

	// Next state: load, sum, nine search steps, then hand over the result.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			rsf_pkg::B_IDLE: if (job_valid) state_d = rsf_pkg::B_SUM;
			rsf_pkg::B_SUM: state_d = rsf_pkg::B_RUN;
			rsf_pkg::B_RUN: if (step_q == 4'd8) state_d = rsf_pkg::B_DONE;
			rsf_pkg::B_DONE: if (store_ok) state_d = rsf_pkg::B_IDLE;
			default: state_d = rsf_pkg::B_IDLE;
		endcase
	end

	// Weighted sums, weight total and sample count.
	always_comb begin
		logic [2:0] w;
		wsum_c = '0;
		cnt_c  = '0;
		for (int ch = 0; ch < 3; ch++) sum_c[ch] = '0;
		for (int k = 0; k < 9; k++) begin
			w = (mode == rsf_pkg::MODE_GAUSS) ? rsf_pkg::gauss_weight(4'(k)) : 3'd1;
			if (job_q.vld[k]) begin
				wsum_c = wsum_c + 5'(w);
				cnt_c  = cnt_c + 4'd1;
				for (int ch = 0; ch < 3; ch++)
					sum_c[ch] = sum_c[ch] + 13'(job_q.px[k][ch*8 +: 8]) * 13'(w);
			end
		end
		for (int ch = 0; ch < 3; ch++) num_c[ch] = {sum_c[ch], 1'b0} + 14'(wsum_c);
	end

	// One division step and one rank test per channel.
	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			trial_c[ch] = {rem_q[ch], low_q[ch][7]};
			fits_c[ch]  = (trial_c[ch] >= {1'b0, den_q});
			cand_c[ch]  = job_q.px[step_q][ch*8 +: 8];
			rank_c[ch]  = '0;
			for (int j = 0; j < 9; j++) begin
				if (job_q.vld[j] && ((job_q.px[j][ch*8 +: 8] < cand_c[ch]) ||
					(job_q.px[j][ch*8 +: 8] == cand_c[ch] && 4'(j) < step_q)))
					rank_c[ch] = rank_c[ch] + 4'd1;
			end
			med_c[ch] = 9'(meda_q[ch]) + 9'(medb_q[ch]) + 9'd1;
			val_c[ch] = (mode == rsf_pkg::MODE_MEDIAN) ? med_c[ch][8:1] : quo_q[ch];
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		unique case (state_q)
			rsf_pkg::B_IDLE: begin
				if (job_valid) job_q <= job;
			end
			rsf_pkg::B_SUM: begin
				step_q <= '0;
				den_q  <= {wsum_c, 1'b0};
				m2_q   <= cnt_c >> 1;
				m1_q   <= cnt_c[0] ? (cnt_c >> 1) : (cnt_c >> 1) - 4'd1;
				for (int ch = 0; ch < 3; ch++) begin
					rem_q[ch] <= num_c[ch][13:8];
					low_q[ch] <= num_c[ch][7:0];
					quo_q[ch] <= '0;
				end
			end
			rsf_pkg::B_RUN: begin
				step_q <= step_q + 4'd1;
				for (int ch = 0; ch < 3; ch++) begin
					if (!step_q[3]) begin
						rem_q[ch] <= fits_c[ch] ? 6'(trial_c[ch] - {1'b0, den_q})
							: trial_c[ch][5:0];
						low_q[ch] <= low_q[ch] << 1;
						quo_q[ch] <= {quo_q[ch][6:0], fits_c[ch]};
					end
					if (job_q.vld[step_q] && rank_c[ch] == m1_q) meda_q[ch] <= cand_c[ch];
					if (job_q.vld[step_q] && rank_c[ch] == m2_q) medb_q[ch] <= cand_c[ch];
				end
			end
			rsf_pkg::B_DONE: begin
				if (store_ok) begin
					res_q.out_blue    <= val_c[0];
					res_q.out_green   <= val_c[1];
					res_q.out_red     <= val_c[2];
					res_q.out_col     <= job_q.col;
					res_q.out_row     <= job_q.row;
					res_q.last_of_run <= job_q.last;
				end
			end
			default: ;
		endcase
	end

	// Output register occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (state_q == rsf_pkg::B_DONE && store_ok) begin
			res_valid_q <= 1'b1;
		end else if (result_ready) begin
			res_valid_q <= 1'b0;
		end
	end

endmodule

@@ src/rgb_3x3_smoothing_filter_unit.sv @@
// Top level of the RGB 3x3 smoothing filter (box, gaussian and median modes).
//
//   Port group    Direction  Handshake           Contents
//   pixel         in         pixel_valid/ready   one raster pixel, blue/green/red
//   result        out        result_valid/ready  filtered pixel with row and column
//   cfg           in         cfg_we              frame width, frame height, mode
//
// The front end takes a new pixel only once through with the last: acceptance with the
// line store read, then window update and line store write, then each released result.
// The back end takes one job at a time: load, sum, nine rank steps with the division
// running in all but the last, hand-over; this shared loop sets the throughput.
// Reset clears configuration, counters, window and control state; the line store needs no clear.
// A two-entry job queue and the output register let either side stall on its own.
module rgb_3x3_smoothing_filter_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [rsf_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [rsf_pkg::CfgDataW-1:0] cfg_data,
	input  logic                         pixel_valid,
	output logic                         pixel_ready,
	input  rsf_pkg::pixel_t              pixel,
	output logic                         result_valid,
	input  logic                         result_ready,
	output rsf_pkg::result_t             result
);

	logic                      fq_valid;
	logic                      fq_ready;
	rsf_pkg::job_t             fq_job;
	logic                      qb_valid;
	logic                      qb_ready;
	rsf_pkg::job_t             qb_job;
	logic [rsf_pkg::ModeW-1:0] mode;

	// Window front end.
	rsf_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.pixel_valid (pixel_valid),
		.pixel_ready (pixel_ready),
		.pixel       (pixel),
		.job_valid   (fq_valid),
		.job_ready   (fq_ready),
		.job         (fq_job),
		.mode        (mode)
	);

	// Job queue.
	rsf_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fq_valid),
		.push_ready (fq_ready),
		.push_data  (fq_job),
		.pop_valid  (qb_valid),
		.pop_ready  (qb_ready),
		.pop_data   (qb_job)
	);

	// Filter back end.
	rsf_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.mode         (mode),
		.job_valid    (qb_valid),
		.job_ready    (qb_ready),
		.job          (qb_job),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule
